>>> rtl/core/interval_capacity_admission_assert.svh
// Assertion macros for the interval capacity admission block.
// Used by the top level only; expects clock and reset in scope.
`ifndef INTERVAL_CAPACITY_ADMISSION_ASSERT_SVH
`define INTERVAL_CAPACITY_ADMISSION_ASSERT_SVH

// same-cycle implication
`define ICA_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ica assertion failed");

// next-cycle implication
`define ICA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ica assertion failed");

`endif

>>> rtl/core/ica_pkg.sv
// Shared types and constants for the interval capacity admission block.
// No dependencies.
package ica_pkg;

   localparam int SPAN_W     = 7;
   localparam int CNT_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = 16'd1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } ica_state_type;

   // check wave passed from cell to cell
   typedef struct packed {
      logic tok;
      logic blk;
   } ica_link_type;

   // broadcast from control to every cell
   typedef struct packed {
      logic [SPAN_W-1:0] span_start;
      logic [SPAN_W-1:0] span_end;
      logic [CNT_W-1:0]  capacity;
      logic              apply;
   } ica_bcast_type;

endpackage

>>> rtl/core/ica_cell.sv
// One segment cell: occupancy count, span check and wave stage.
// Depends on ica_pkg.
module ica_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CMP_W      = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ica_pkg::ica_bcast_type bcast,
   input  ica_pkg::ica_link_type  prev_link,
   output ica_pkg::ica_link_type  next_link
);
   import ica_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   ica_link_type     link_ff, link_in;
   logic             in_span;
   logic             full;

   assign in_span = (CMP_W'(CELL_INDEX) >= CMP_W'(bcast.span_start)) &&
                    (CMP_W'(CELL_INDEX) <  CMP_W'(bcast.span_end));
   assign full    = count_ff >= bcast.capacity;

   always_comb begin
      link_in.tok = prev_link.tok;
      link_in.blk = prev_link.blk | (prev_link.tok & in_span & full);
      count_in    = count_ff + CNT_W'(bcast.apply & in_span);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         link_ff  <= '0;
      end else begin
         count_ff <= count_in;
         link_ff  <= link_in;
      end
   end

   assign next_link = link_ff;

endmodule

>>> rtl/core/interval_capacity_admission.sv
// Top level of the interval capacity admission block: control, CSR, cell row.
// Depends on ica_pkg, ica_cell and interval_capacity_admission_assert.svh.
//
//   port group | direction | beat contents
//   req_*      | in        | span_start, span_end
//   rsp_*      | out       | accepted
//   csr_*      | in/out    | capacity register (APB-style)
//
// From accept to result, the check wave walks the cell row one cell a cycle,
// then the commit state updates the counts.
// One item is in flight at a time; the result register lets the next beat enter
// while a result waits. Synchronous active-high reset clears all counts and
// sets capacity to one. A stalled result holds the commit until the slot frees.
module interval_capacity_admission #(
   parameter int NUM_SEGMENTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ica_pkg::SPAN_W-1:0]          req_span_start,
   input  logic [ica_pkg::SPAN_W-1:0]          req_span_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ica_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ica_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ica_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import ica_pkg::*;

   `include "interval_capacity_admission_assert.svh"

   localparam int IDX_W = $clog2(NUM_SEGMENTS + 1);
   localparam int CMP_W = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;

   ica_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  capacity_ff, capacity_in;
   logic [SPAN_W-1:0] start_ff, start_in;
   logic [SPAN_W-1:0] end_ff, end_in;
   logic              launch_ff, launch_in;
   logic              grant_ff, grant_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;

   logic              req_take;
   logic              csr_write;
   logic              slot_free;
   logic              commit;
   ica_bcast_type     bcast;
   ica_link_type      chain [NUM_SEGMENTS+1];
   logic [NUM_SEGMENTS-1:0] tok_vec;

   assign req_take  = req_valid & ~req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign commit    = (state_ff == ST_COMMIT) & slot_free;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CAPACITY) ?
                       CSR_DATA_W'(capacity_ff) : '0;

   assign chain[0].tok = launch_ff;
   assign chain[0].blk = (capacity_ff == '0);

   always_comb begin
      bcast.span_start = start_ff;
      bcast.span_end   = end_ff;
      bcast.capacity   = capacity_ff;
      bcast.apply      = commit & grant_ff;
   end

   for (genvar g = 0; g < NUM_SEGMENTS; g++) begin : g_cell
      ica_cell #(
         .CELL_INDEX (g),
         .CMP_W      (CMP_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .prev_link (chain[g]),
         .next_link (chain[g+1])
      );
      assign tok_vec[g] = chain[g+1].tok;
   end

   always_comb begin
      state_in        = state_ff;
      capacity_in     = capacity_ff;
      start_in        = start_ff;
      end_in          = end_ff;
      launch_in       = 1'b0;
      grant_in        = grant_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_CAPACITY)) begin
         capacity_in = csr_pwdata[CNT_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               start_in  = req_span_start;
               end_in    = req_span_end;
               launch_in = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[NUM_SEGMENTS].tok) begin
               grant_in = ~chain[NUM_SEGMENTS].blk;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = grant_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff        <= start_in;
      end_ff          <= end_in;
      grant_ff        <= grant_in;
      rsp_accepted_ff <= rsp_accepted_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

   `ICA_ASSERT_NOW(a_wave_single, 1'b1, $onehot0(tok_vec))
   `ICA_ASSERT_NOW(a_tail_in_scan, chain[NUM_SEGMENTS].tok, state_ff == ST_SCAN)
   `ICA_ASSERT_NEXT(a_accept_launches, req_take, launch_ff && state_ff == ST_SCAN)
   `ICA_ASSERT_NEXT(a_commit_loads_rsp, commit, rsp_valid_ff && rsp_accepted_ff == $past(grant_ff))

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for interval_capacity_admission: a directed table, then random span requests
// checked beat by beat against a per-segment occupancy predictor. Needs ica_pkg and the RTL.
module tb_top;
   import ica_pkg::*;

   localparam int SEGMENTS     = 64;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CAP_SETTINGS = 6;
   localparam int DRAIN_CYCLES = SEGMENTS + 16;
   localparam int MAX_PRINTS   = 20;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {CSR_IDX_CAPACITY, 2'b00};

   typedef enum logic {ROW_CFG, ROW_SPAN} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [CNT_W-1:0]  cap;
      logic [SPAN_W-1:0] span_start;
      logic [SPAN_W-1:0] span_end;
      logic              typed;
      logic              grant;
   } plan_row_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [SPAN_W-1:0]     req_span_start = '0;
   logic [SPAN_W-1:0]     req_span_end   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_accepted;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // occupancy predictor
   logic [CNT_W-1:0] seg_count [SEGMENTS];
   logic [CNT_W-1:0] cap_model = CAPACITY_RESET;

   bit           grant_q [$];
   plan_row_type plan [$];

   int  errors        = 0;
   int  cycles        = 0;
   int  requests_sent = 0;
   int  results_seen  = 0;
   int  grants_seen   = 0;
   int  cap_writes    = 0;
   int  src_idle_pct  = 8;
   int  snk_stall_pct = 73;
   bit  want;

   interval_capacity_admission #(.NUM_SEGMENTS(SEGMENTS)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_span_start(req_span_start),
      .req_span_end  (req_span_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accepted  (rsp_accepted),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int wanted);
      if (errors < MAX_PRINTS)
         $display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, wanted, cycles);
      errors++;
   endtask

   // grant decision and count update for one span
   function automatic bit admit_span(logic [SPAN_W-1:0] s, logic [SPAN_W-1:0] e);
      int hi;
      int i;
      logic [CNT_W-1:0] peak;
      hi = (e > SEGMENTS) ? SEGMENTS : int'(e);
      peak = '0;
      for (i = s; i < hi; i++)
         if (seg_count[i] > peak) peak = seg_count[i];
      if (peak < cap_model) begin
         for (i = s; i < hi; i++) seg_count[i] = seg_count[i] + 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [CNT_W-1:0] busiest_count();
      logic [CNT_W-1:0] peak;
      peak = '0;
      foreach (seg_count[i])
         if (seg_count[i] > peak) peak = seg_count[i];
      return peak;
   endfunction

   task automatic add_row(row_kind_type kind, int cap, int s, int e, bit typed, bit grant);
      plan_row_type row;
      row.kind       = kind;
      row.cap        = CNT_W'(cap);
      row.span_start = SPAN_W'(s);
      row.span_end   = SPAN_W'(e);
      row.typed      = typed;
      row.grant      = grant;
      plan.push_back(row);
   endtask

   task automatic send_span(logic [SPAN_W-1:0] s, logic [SPAN_W-1:0] e, bit typed, bit grant);
      bit predicted;
      req_valid      <= 1'b1;
      req_span_start <= s;
      req_span_end   <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = admit_span(s, e);
      grant_q.push_back(typed ? grant : predicted);
      requests_sent++;
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // sender holds off until every pending result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CNT_W-1:0] cap);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= CSR_DATA_W'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cap_model = cap;
      cap_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(cap))
         report_mismatch("capacity readback", int'(csr_prdata), int'(cap));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grant_q.size() == 0) begin
            report_mismatch("unexpected accepted beat", int'(rsp_accepted), -1);
         end else begin
            want = grant_q.pop_front();
            if (rsp_accepted !== want)
               report_mismatch("accepted", int'(rsp_accepted), int'(want));
            results_seen++;
            if (rsp_accepted === 1'b1) grants_seen++;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < snk_stall_pct);
   end

   initial begin
      int r;
      int s;
      int e;
      int setting;
      logic [CNT_W-1:0] cap;

      foreach (seg_count[i]) seg_count[i] = '0;

      // reset state: capacity one, all counts zero
      add_row(ROW_SPAN, 0,   0,  64, 1, 1);
      add_row(ROW_SPAN, 0,   0,  64, 1, 0);
      add_row(ROW_SPAN, 0,   5,   5, 1, 1);
      add_row(ROW_SPAN, 0, 127, 127, 1, 1);
      add_row(ROW_SPAN, 0,  64, 127, 1, 1);
      add_row(ROW_SPAN, 0,  63, 127, 1, 0);
      // zero capacity refuses even an empty span
      add_row(ROW_CFG,  0,   0,   0, 0, 0);
      add_row(ROW_SPAN, 0,  10,   3, 1, 0);
      add_row(ROW_SPAN, 0,   0,   0, 1, 0);
      add_row(ROW_CFG,  3,   0,   0, 0, 0);
      add_row(ROW_SPAN, 0,   0, 127, 1, 1);
      add_row(ROW_SPAN, 0,  62,  64, 1, 1);
      add_row(ROW_SPAN, 0,  63,  64, 1, 0);
      add_row(ROW_SPAN, 0,   0,  62, 1, 1);
      add_row(ROW_SPAN, 0,   0,   1, 1, 0);
      // capacity dropped below the stored counts
      add_row(ROW_CFG,  2,   0,   0, 0, 0);
      add_row(ROW_SPAN, 0,  30,  31, 1, 0);
      add_row(ROW_SPAN, 0, 100,  50, 1, 1);
      add_row(ROW_CFG,  65535, 0, 0, 0, 0);
      add_row(ROW_SPAN, 0,   0, 127, 1, 1);
      add_row(ROW_SPAN, 0, 127,   0, 1, 1);
      add_row(ROW_SPAN, 0,   1, 126, 0, 0);
      add_row(ROW_SPAN, 0,  64,  64, 1, 1);

      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            drain();
            write_capacity(plan[i].cap);
         end else begin
            send_span(plan[i].span_start, plan[i].span_end, plan[i].typed, plan[i].grant);
         end
      end

      for (setting = 0; setting < CAP_SETTINGS; setting++) begin
         case (setting / 2)
            0: begin
               src_idle_pct  = 8;
               snk_stall_pct = 73;
            end
            1: begin
               src_idle_pct  = 73;
               snk_stall_pct = 8;
            end
            default: begin
               src_idle_pct  = 0;
               snk_stall_pct = 0;
            end
         endcase
         drain();
         if (setting == 3)
            cap = '1;
         else
            cap = busiest_count() + CNT_W'($urandom_range(1, 6));
         write_capacity(cap);
         repeat (RANDOM_ITEMS / CAP_SETTINGS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               s = $urandom_range(0, SEGMENTS - 1);
               e = s + $urandom_range(0, 9);
            end else if (r < 85) begin
               s = $urandom_range(0, 127);
               e = $urandom_range(0, 127);
            end else begin
               s = $urandom_range(0, 20);
               e = $urandom_range(40, 127);
            end
            send_span(SPAN_W'(s), SPAN_W'(e), 1'b0, 1'b0);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d span requests: %0d granted, %0d refused, %0d capacity writes",
               requests_sent, grants_seen, results_seen - grants_seen, cap_writes);
      $display("idle mixes: sender-light/receiver-heavy, the reverse, and back to back");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
